// ----- hdl/jlp_pkg.sv -----
// ----------------------------------------------------------------------------
// jlp_pkg
// shared types and constants of the jerk-limited pid step
// ----------------------------------------------------------------------------
package jlp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JERK_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TICKS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FALLING = 3'd7;

    localparam logic [14:0] SETTLE_BAND_RESET = 15'd40;

    // finish reason codes
    localparam logic [1:0] WHY_RUNNING = 2'd0;
    localparam logic [1:0] WHY_SETTLED = 2'd1;
    localparam logic [1:0] WHY_TIMEOUT = 2'd2;

    localparam logic [6:0] DRIVE_MAX = 7'd127;

    localparam logic signed [39:0] PWR_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] PWR_MIN = {1'b1, {39{1'b0}}};

    typedef enum logic [2:0]
    {
        KIND_START,
        KIND_IDLE,
        KIND_TIMEOUT,
        KIND_SETTLED,
        KIND_RUN
    } kind_t;

    typedef struct packed
    {
        logic signed [15:0] target;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [15:0]        jerk_step;
        logic [14:0]        settle_band;
        logic [15:0]        limit_ticks;
        logic               limit_falling;
    } cfg_t;

    // tracking stage to product stage
    typedef struct packed
    {
        logic               valid;
        kind_t              kind;
        logic signed [16:0] err;
        logic signed [17:0] deriv;
        logic signed [31:0] sum;
        logic [31:0]        slew;
    } track_t;

    // power stage to shaping stage
    typedef struct packed
    {
        logic               valid;
        kind_t              kind;
        logic signed [39:0] power;
        logic [31:0]        slew;
    } power_t;

endpackage

// ----- hdl/jlp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// jlp_cfg_regs
// configuration register bank written through a plain write port
// ----------------------------------------------------------------------------
module jlp_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jlp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output jlp_pkg::cfg_t                   cfg
);

    jlp_pkg::cfg_t cfg_reg;
    jlp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                jlp_pkg::CFG_TARGET:        cfg_next.target        = cfg_data;
                jlp_pkg::CFG_GAIN_P:        cfg_next.gain_p        = cfg_data;
                jlp_pkg::CFG_GAIN_I:        cfg_next.gain_i        = cfg_data;
                jlp_pkg::CFG_GAIN_D:        cfg_next.gain_d        = cfg_data;
                jlp_pkg::CFG_JERK_STEP:     cfg_next.jerk_step     = cfg_data;
                jlp_pkg::CFG_SETTLE_BAND:   cfg_next.settle_band   = cfg_data[14:0];
                jlp_pkg::CFG_LIMIT_TICKS:   cfg_next.limit_ticks   = cfg_data;
                jlp_pkg::CFG_LIMIT_FALLING: cfg_next.limit_falling = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{target: '0, gain_p: '0, gain_i: '0, gain_d: '0,
                         jerk_step: '0, settle_band: jlp_pkg::SETTLE_BAND_RESET,
                         limit_ticks: '0, limit_falling: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/jlp_track.sv -----
// ----------------------------------------------------------------------------
// jlp_track
// move state, error terms and the start / idle / timeout / settle decision
// ----------------------------------------------------------------------------
module jlp_track
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                accept,
    input  logic                begin_req,
    input  logic signed [15:0]  measured,
    input  jlp_pkg::cfg_t       cfg,
    output jlp_pkg::track_t     trk
);

    logic signed [16:0] last_error_reg, last_error_next;
    logic signed [31:0] error_sum_reg, error_sum_next;
    logic [31:0]        slew_limit_reg, slew_limit_next;
    logic [15:0]        tick_count_reg, tick_count_next;
    logic               running_reg, running_next;

    logic               valid_reg;
    jlp_pkg::track_t    trk_reg, trk_next;

    logic signed [16:0] err;
    logic signed [17:0] deriv;
    logic [32:0]        sum_wide;
    logic signed [31:0] sum_sat;
    logic [32:0]        slew_wide;
    logic [31:0]        slew_sat;
    logic [16:0]        err_mag;
    logic               settled;
    logic               timed_out;
    jlp_pkg::kind_t     kind;

    always_comb
    begin
        err       = {cfg.target[15], cfg.target} - {measured[15], measured};
        deriv     = {err[16], err} - {last_error_reg[16], last_error_reg};
        sum_wide  = {error_sum_reg[31], error_sum_reg} + {{16{err[16]}}, err};
        // integral saturates to the 32 bit signed range
        if (sum_wide[32] != sum_wide[31])
            sum_sat = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            sum_sat = sum_wide[31:0];
        slew_wide = {1'b0, slew_limit_reg} + {17'd0, cfg.jerk_step};
        slew_sat  = slew_wide[32] ? {32{1'b1}} : slew_wide[31:0];
        err_mag   = err[16] ? 17'(-err) : 17'(err);
        settled   = err_mag < {2'b00, cfg.settle_band};
        timed_out = tick_count_reg >= cfg.limit_ticks;

        if (begin_req)
            kind = jlp_pkg::KIND_START;
        else if (!running_reg)
            kind = jlp_pkg::KIND_IDLE;
        else if (timed_out)
            kind = jlp_pkg::KIND_TIMEOUT;
        else if (settled)
            kind = jlp_pkg::KIND_SETTLED;
        else
            kind = jlp_pkg::KIND_RUN;

        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;
        slew_limit_next = slew_limit_reg;
        tick_count_next = tick_count_reg;
        running_next    = running_reg;

        case (kind)
            jlp_pkg::KIND_START:
            begin
                last_error_next = err;
                error_sum_next  = '0;
                slew_limit_next = {16'd0, cfg.jerk_step};
                tick_count_next = '0;
                running_next    = 1'b1;
            end
            jlp_pkg::KIND_TIMEOUT:
            begin
                running_next = 1'b0;
            end
            jlp_pkg::KIND_SETTLED,
            jlp_pkg::KIND_RUN:
            begin
                last_error_next = err;
                error_sum_next  = sum_sat;
                slew_limit_next = slew_sat;
                tick_count_next = tick_count_reg + 16'd1;
                running_next    = (kind == jlp_pkg::KIND_RUN);
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase

        trk_next.valid = accept;
        trk_next.kind  = kind;
        trk_next.err   = err;
        trk_next.deriv = deriv;
        trk_next.sum   = sum_sat;
        trk_next.slew  = slew_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            slew_limit_reg <= '0;
            tick_count_reg <= '0;
            running_reg    <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_error_reg <= last_error_next;
                error_sum_reg  <= error_sum_next;
                slew_limit_reg <= slew_limit_next;
                tick_count_reg <= tick_count_next;
                running_reg    <= running_next;
            end
            if (advance)
                valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            trk_reg <= trk_next;
    end

    always_comb
    begin
        trk       = trk_reg;
        trk.valid = valid_reg;
    end

endmodule

// ----- hdl/jlp_power.sv -----
// ----------------------------------------------------------------------------
// jlp_power
// gain products, then their sum saturated to the 40 bit q32.8 range
// ----------------------------------------------------------------------------
module jlp_power
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  jlp_pkg::track_t     trk,
    input  jlp_pkg::cfg_t       cfg,
    output jlp_pkg::power_t     pwr
);

    logic signed [16:0] err_s;
    logic signed [17:0] deriv_s;
    logic signed [31:0] sum_s;
    logic signed [15:0] gp_s, gi_s, gd_s;

    logic signed [32:0] prod_p_next, prod_p_reg;
    logic signed [47:0] prod_i_next, prod_i_reg;
    logic signed [33:0] prod_d_next, prod_d_reg;
    logic               prod_valid_reg;
    jlp_pkg::kind_t     prod_kind_reg;
    logic [31:0]        prod_slew_reg;

    logic [49:0]        total;
    logic               total_fits;
    logic signed [39:0] power_next;

    logic               pwr_valid_reg;
    jlp_pkg::power_t    pwr_reg;

    assign err_s   = trk.err;
    assign deriv_s = trk.deriv;
    assign sum_s   = trk.sum;
    assign gp_s    = cfg.gain_p;
    assign gi_s    = cfg.gain_i;
    assign gd_s    = cfg.gain_d;

    assign prod_p_next = err_s * gp_s;
    assign prod_i_next = sum_s * gi_s;
    assign prod_d_next = deriv_s * gd_s;

    always_comb
    begin
        total = {{17{prod_p_reg[32]}}, prod_p_reg}
              + {{2{prod_i_reg[47]}}, prod_i_reg}
              + {{16{prod_d_reg[33]}}, prod_d_reg};
        total_fits = (&total[49:39]) || !(|total[49:39]);
        if (total_fits)
            power_next = total[39:0];
        else
            power_next = total[49] ? jlp_pkg::PWR_MIN : jlp_pkg::PWR_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            pwr_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg <= trk.valid;
            pwr_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_p_reg    <= prod_p_next;
            prod_i_reg    <= prod_i_next;
            prod_d_reg    <= prod_d_next;
            prod_kind_reg <= trk.kind;
            prod_slew_reg <= trk.slew;
            pwr_reg.kind  <= prod_kind_reg;
            pwr_reg.power <= power_next;
            pwr_reg.slew  <= prod_slew_reg;
            pwr_reg.valid <= 1'b0;
        end
    end

    always_comb
    begin
        pwr       = pwr_reg;
        pwr.valid = pwr_valid_reg;
    end

endmodule

// ----- hdl/jlp_shape.sv -----
// ----------------------------------------------------------------------------
// jlp_shape
// slew limiting against the previous power, drive saturation, result register
// ----------------------------------------------------------------------------
module jlp_shape
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  jlp_pkg::power_t     pwr,
    input  logic                limit_falling,
    output logic                result_valid,
    output logic signed [7:0]   drive,
    output logic                finished,
    output logic [1:0]          why_finished
);

    logic signed [39:0] last_power_reg;

    logic signed [41:0] power_x, last_x, slew_x, diff_x, lim_x;
    logic signed [39:0] limited;
    logic signed [40:0] p41, abs41;
    logic [32:0]        mag;
    logic [6:0]         mag_sat;
    logic signed [7:0]  drive_run;

    logic               valid_reg;
    logic signed [7:0]  drive_reg, drive_next;
    logic               finished_reg, finished_next;
    logic [1:0]         why_reg, why_next;

    always_comb
    begin
        power_x = {{2{pwr.power[39]}}, pwr.power};
        last_x  = {{2{last_power_reg[39]}}, last_power_reg};
        slew_x  = {10'd0, pwr.slew};
        diff_x  = power_x - last_x;
        lim_x   = power_x;
        if (!limit_falling)
        begin
            if (diff_x > slew_x)
                lim_x = last_x + slew_x;
        end
        else
        begin
            if (diff_x < -slew_x)
                lim_x = last_x - slew_x;
        end
        // the limited value lies between last and new power, so it fits
        limited = lim_x[39:0];

        p41     = {limited[39], limited};
        abs41   = limited[39] ? -p41 : p41;
        mag     = abs41[40:8];
        mag_sat = (mag > {26'd0, jlp_pkg::DRIVE_MAX}) ? jlp_pkg::DRIVE_MAX : mag[6:0];
        drive_run = limited[39] ? -{1'b0, mag_sat} : {1'b0, mag_sat};

        drive_next    = '0;
        finished_next = 1'b1;
        why_next      = jlp_pkg::WHY_RUNNING;
        case (pwr.kind)
            jlp_pkg::KIND_START:
            begin
                finished_next = 1'b0;
            end
            jlp_pkg::KIND_IDLE:
            begin
                finished_next = 1'b1;
            end
            jlp_pkg::KIND_TIMEOUT:
            begin
                why_next = jlp_pkg::WHY_TIMEOUT;
            end
            jlp_pkg::KIND_SETTLED:
            begin
                why_next = jlp_pkg::WHY_SETTLED;
            end
            jlp_pkg::KIND_RUN:
            begin
                drive_next    = drive_run;
                finished_next = 1'b0;
            end
            default:
            begin
                finished_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_power_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= pwr.valid;
            if (pwr.valid && pwr.kind == jlp_pkg::KIND_START)
                last_power_reg <= '0;
            else if (pwr.valid && pwr.kind == jlp_pkg::KIND_RUN)
                last_power_reg <= limited;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg    <= drive_next;
            finished_reg <= finished_next;
            why_reg      <= why_next;
        end
    end

    assign result_valid = valid_reg;
    assign drive        = drive_reg;
    assign finished     = finished_reg;
    assign why_finished = why_reg;

endmodule

// ----- hdl/jerk_limited_pid_step.sv -----
// ----------------------------------------------------------------------------
// jerk_limited_pid_step
// slew-rate limited pid controller, one control tick per item
// ----------------------------------------------------------------------------
// throughput: one item per cycle while result_stall does not hold a valid result;
//   the four register stages (track, products, power sum, shaping) all move
//   together, and the last_power loop closes inside the shaping stage
// reset: rst_n clears the move state, the pipe valids and the configuration
//   registers (settle_band to 40); no move is running afterwards
// ----------------------------------------------------------------------------
module jerk_limited_pid_step
(
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_we,
    input  logic [jlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jlp_pkg::CFG_DATA_W-1:0]  cfg_data,

    // tick items
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  logic                            begin_req,
    input  logic signed [15:0]              measured,

    // result items
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [7:0]               drive,
    output logic                            finished,
    output logic [1:0]                      why_finished
);

    jlp_pkg::cfg_t      cfg;
    jlp_pkg::track_t    trk;
    jlp_pkg::power_t    pwr;

    logic advance;
    logic accept;

    // the whole pipe moves unless a valid result sits stalled at the output
    assign advance    = !(result_valid && result_stall);
    assign tick_stall = !advance;
    assign accept     = tick_valid && advance;

    jlp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage 1: error terms, integral, slew growth and the item kind
    jlp_track u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .accept    (accept),
        .begin_req (begin_req),
        .measured  (measured),
        .cfg       (cfg),
        .trk       (trk)
    );

    // stages 2 and 3: three gain products, then the saturated sum
    jlp_power u_power
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .trk     (trk),
        .cfg     (cfg),
        .pwr     (pwr)
    );

    // stage 4: slew limit against last power and the result register
    jlp_shape u_shape
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .pwr           (pwr),
        .limit_falling (cfg.limit_falling),
        .result_valid  (result_valid),
        .drive         (drive),
        .finished      (finished),
        .why_finished  (why_finished)
    );

    // a finished move always drives zero
    a_finished_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && finished) |-> (drive == 8'sd0))
        else $error("finished result with nonzero drive");

    // a finish reason is only given with finished set
    a_why_needs_finished : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && why_finished != jlp_pkg::WHY_RUNNING) |-> finished)
        else $error("finish reason without finished");

    // drive stays within the symmetric range
    a_drive_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drive != 8'sh80))
        else $error("drive outside +-127");

    // an accepted tick reaches the output once the track, product, power sum and shaping registers have each advanced
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && advance ##1 advance ##1 advance ##1 advance) |=> result_valid)
        else $error("result item missing after four cycles");

endmodule
